/* rtl/core/i2cbs_pkg.sv */
package i2cbs_pkg;

   localparam int DEV_ADDR_W  = 7;
   localparam int BYTE_W      = 8;
   localparam int STORE_DEPTH = 256;
   localparam int PTR_W       = $clog2(STORE_DEPTH);
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 8;

   localparam logic [DEV_ADDR_W-1:0] READ_DEV_RESET  = 7'h31;
   localparam logic [DEV_ADDR_W-1:0] WRITE_DEV_RESET = 7'h32;
   localparam logic [BYTE_W-1:0]     ERASED_BYTE     = 8'hFF;

   typedef enum logic [1:0] {
      RESP_NONE = 2'd0,
      RESP_ACK  = 2'd1,
      RESP_DONE = 2'd2
   } resp_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_READ_DEV  = 8'd0,
      CSR_WRITE_DEV = 8'd1
   } csr_index_type;

   typedef struct packed {
      logic              bus_error;
      logic              collision;
      logic              address_stop_flag;
      logic              address_phase;
      logic              data_flag;
      logic              direction_read;
      logic              master_nack;
      logic [BYTE_W-1:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      resp_type response;
      logic     tx_valid;
      logic     use_store;
   } rsp_item_type;

endpackage

/* rtl/core/i2cbs_channels.sv */
interface i2cbs_req_if import i2cbs_pkg::*;;
   logic              valid;
   logic              ready;
   logic              bus_error;
   logic              collision;
   logic              address_stop_flag;
   logic              address_phase;
   logic              data_flag;
   logic              direction_read;
   logic              master_nack;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, bus_error, collision, address_stop_flag, address_phase,
                   data_flag, direction_read, master_nack, rx_byte, input ready);
   modport sink   (input valid, bus_error, collision, address_stop_flag, address_phase,
                   data_flag, direction_read, master_nack, rx_byte, output ready);
endinterface

interface i2cbs_rsp_if import i2cbs_pkg::*;;
   logic              valid;
   logic              ready;
   logic [1:0]        response;
   logic              tx_valid;
   logic [BYTE_W-1:0] tx_byte;

   modport source (output valid, response, tx_valid, tx_byte, input ready);
   modport sink   (input valid, response, tx_valid, tx_byte, output ready);
endinterface

interface i2cbs_csr_if import i2cbs_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] reg_index;
   logic [CSR_DATA_W-1:0]  wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

/* rtl/core/i2c_slave_byte_store_responder_unit.sv */
// I2C slave event responder in front of a 256-byte store. Each request is one bus
// event (status flags plus a byte) and yields exactly one result: a bus command and,
// on a read, the byte to transmit. Requests are taken one per clock unless both
// registers are full. An accepted request sits in the input register, where the event
// is decoded, state is updated and the store is written or read; the result then loads
// into the result register once that register is free, and is offered from there. The
// store read data is registered at the same edge as the result. A stalled result holds
// both registers, and once both are full the request channel stalls. Device addresses
// are set through the csr channel and should be written only while idle.
module i2c_slave_byte_store_responder_unit import i2cbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   i2cbs_req_if.sink   req_bus,
   i2cbs_rsp_if.source rsp_bus,
   i2cbs_csr_if.sink   csr_bus
);

   logic [DEV_ADDR_W-1:0] read_dev_ff;
   logic [DEV_ADDR_W-1:0] write_dev_ff;

   logic [DEV_ADDR_W-1:0] cur_dev_ff, cur_dev_in;
   logic [PTR_W-1:0]      ptr_ff, ptr_in;
   logic                  sent_ff, sent_in;
   logic                  read_xfer_ff, read_xfer_in;

   req_item_type a_item_ff;
   logic         a_valid_ff;
   rsp_item_type b_item_ff, b_item_in;
   logic         b_valid_ff;

   logic a_fire, a_ready, b_ready;

   logic              wr_en, rd_en;
   logic [PTR_W-1:0]  rd_addr;
   logic [BYTE_W-1:0] rd_data;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         read_dev_ff  <= READ_DEV_RESET;
         write_dev_ff <= WRITE_DEV_RESET;
      end else if (csr_bus.valid) begin
         if (csr_bus.reg_index == CSR_READ_DEV) begin
            read_dev_ff <= csr_bus.wr_data[DEV_ADDR_W-1:0];
         end else if (csr_bus.reg_index == CSR_WRITE_DEV) begin
            write_dev_ff <= csr_bus.wr_data[DEV_ADDR_W-1:0];
         end
      end
   end

   // Two-entry pipeline; a request is taken whenever the input register is empty or
   // moves on to the result register in the same cycle.
   assign b_ready       = !b_valid_ff || rsp_bus.ready;
   assign a_ready       = !a_valid_ff || b_ready;
   assign a_fire        = a_valid_ff && b_ready;
   assign req_bus.ready = a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= req_bus.valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && a_ready) begin
         a_item_ff.bus_error         <= req_bus.bus_error;
         a_item_ff.collision         <= req_bus.collision;
         a_item_ff.address_stop_flag <= req_bus.address_stop_flag;
         a_item_ff.address_phase     <= req_bus.address_phase;
         a_item_ff.data_flag         <= req_bus.data_flag;
         a_item_ff.direction_read    <= req_bus.direction_read;
         a_item_ff.master_nack       <= req_bus.master_nack;
         a_item_ff.rx_byte           <= req_bus.rx_byte;
      end
      if (a_fire) begin
         b_item_ff <= b_item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_dev_ff   <= '0;
         ptr_ff       <= '0;
         sent_ff      <= 1'b0;
         read_xfer_ff <= 1'b0;
      end else if (a_fire) begin
         cur_dev_ff   <= cur_dev_in;
         ptr_ff       <= ptr_in;
         sent_ff      <= sent_in;
         read_xfer_ff <= read_xfer_in;
      end
   end

   // Event decode in priority order.
   always_comb begin
      cur_dev_in          = cur_dev_ff;
      ptr_in              = ptr_ff;
      sent_in             = sent_ff;
      read_xfer_in        = read_xfer_ff;
      b_item_in.response  = RESP_NONE;
      b_item_in.tx_valid  = 1'b0;
      b_item_in.use_store = 1'b0;
      wr_en               = 1'b0;
      rd_en               = 1'b0;
      rd_addr             = ptr_ff;
      priority if (a_item_ff.bus_error || a_item_ff.collision) begin
         b_item_in.response = RESP_NONE;
      end else if (a_item_ff.address_stop_flag && a_item_ff.address_phase) begin
         read_xfer_in = a_item_ff.direction_read;
         sent_in      = 1'b0;
         // A repeated read to the same device keeps its pointer.
         if (a_item_ff.rx_byte[BYTE_W-1:1] != cur_dev_ff || !a_item_ff.direction_read) begin
            ptr_in     = '0;
            cur_dev_in = a_item_ff.rx_byte[BYTE_W-1:1];
         end
         b_item_in.response = RESP_ACK;
      end else if (a_item_ff.address_stop_flag) begin
         b_item_in.response = RESP_NONE;
      end else if (a_item_ff.data_flag) begin
         if (!a_item_ff.direction_read && ptr_ff == '0) begin
            ptr_in = a_item_ff.rx_byte;
         end
         if (a_item_ff.direction_read || (ptr_ff == '0 && read_xfer_ff)) begin
            if (a_item_ff.master_nack && sent_ff) begin
               b_item_in.response = RESP_DONE;
            end else begin
               rd_addr             = a_item_ff.direction_read ? ptr_ff : a_item_ff.rx_byte;
               rd_en               = a_fire;
               ptr_in              = rd_addr + 1'b1;
               sent_in             = 1'b1;
               b_item_in.tx_valid  = 1'b1;
               b_item_in.use_store = (cur_dev_ff == read_dev_ff);
               b_item_in.response  = RESP_ACK;
            end
         end else if (ptr_ff == '0) begin
            b_item_in.response = RESP_ACK;
         end else begin
            wr_en              = a_fire && (cur_dev_ff == write_dev_ff);
            ptr_in             = ptr_ff + 1'b1;
            b_item_in.response = RESP_ACK;
         end
      end else begin
         b_item_in.response = RESP_NONE;
      end
   end

   i2cbs_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (ptr_ff),
      .wr_data (a_item_ff.rx_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_bus.valid    = b_valid_ff;
   assign rsp_bus.response = b_item_ff.response;
   assign rsp_bus.tx_valid = b_item_ff.tx_valid;
   assign rsp_bus.tx_byte  = !b_item_ff.tx_valid ? '0 :
                             (b_item_ff.use_store ? rd_data : ERASED_BYTE);

endmodule

/* rtl/core/i2cbs_store.sv */
module i2cbs_store import i2cbs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [PTR_W-1:0]  wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [PTR_W-1:0]  rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0]      mem [STORE_DEPTH];
   logic [STORE_DEPTH-1:0] written_ff;
   logic [BYTE_W-1:0]      rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // An entry never written since reset still reads as erased.
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= written_ff[rd_addr] ? mem[rd_addr] : ERASED_BYTE;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* tb/i2c_slave_byte_store_responder_unit_test.sv */
module i2c_slave_byte_store_responder_unit_test;
   import i2cbs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 6;

   typedef struct packed {
      resp_type          response;
      logic              tx_valid;
      logic [BYTE_W-1:0] tx_byte;
   } bus_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   i2cbs_req_if req_bus ();
   i2cbs_rsp_if rsp_bus ();
   i2cbs_csr_if csr_bus ();

   i2c_slave_byte_store_responder_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #2 clock = ~clock;

   // Shadow copy of the slave: device addresses, transfer state and the store.
   logic [DEV_ADDR_W-1:0] read_dev_addr;
   logic [DEV_ADDR_W-1:0] write_dev_addr;
   logic [DEV_ADDR_W-1:0] active_device;
   logic [PTR_W-1:0]      store_pointer;
   logic                  byte_sent;
   logic                  reading;
   logic [BYTE_W-1:0]     stored_bytes [STORE_DEPTH];

   bus_reply_type expected_replies [$];
   int unsigned   requests_accepted = 0;
   int unsigned   mismatch_count = 0;
   int unsigned   quiet_cycles = 0;
   int unsigned   burst_left = 0;
   bit            gaps_enabled = 1'b1;
   int unsigned   holdoff_request = 0;

   task automatic report_mismatch(input string detail);
      mismatch_count++;
      if (mismatch_count <= 100)
         $display("[%0t] mismatch: %s", $realtime, detail);
   endtask

   function automatic void transmit_next(input logic nack, inout bus_reply_type reply);
      if (nack && byte_sent) begin
         reply.response = RESP_DONE;
      end else begin
         reply.tx_byte  = (active_device == read_dev_addr) ? stored_bytes[store_pointer]
                                                           : ERASED_BYTE;
         store_pointer  = store_pointer + 1'b1;
         byte_sent      = 1'b1;
         reply.tx_valid = 1'b1;
         reply.response = RESP_ACK;
      end
   endfunction

   function automatic void respond_to_event(input req_item_type ev);
      bus_reply_type         reply;
      logic [DEV_ADDR_W-1:0] dev;
      reply.response = RESP_NONE;
      reply.tx_valid = 1'b0;
      reply.tx_byte  = '0;
      // Bus error, collision, stop and an event with no flag all leave the state alone.
      if (!ev.bus_error && !ev.collision) begin
         if (ev.address_stop_flag && ev.address_phase) begin
            dev       = ev.rx_byte[BYTE_W-1:1];
            reading   = ev.direction_read;
            byte_sent = 1'b0;
            // A repeated read to the same device keeps its pointer.
            if (dev != active_device || !ev.direction_read) begin
               store_pointer = '0;
               active_device = dev;
            end
            reply.response = RESP_ACK;
         end else if (!ev.address_stop_flag && ev.data_flag) begin
            if (ev.direction_read) begin
               transmit_next(ev.master_nack, reply);
            end else if (store_pointer == '0) begin
               store_pointer = ev.rx_byte;
               if (reading)
                  transmit_next(ev.master_nack, reply);
               else
                  reply.response = RESP_ACK;
            end else begin
               if (active_device == write_dev_addr)
                  stored_bytes[store_pointer] = ev.rx_byte;
               store_pointer  = store_pointer + 1'b1;
               reply.response = RESP_ACK;
            end
         end
      end
      expected_replies.push_back(reply);
   endfunction

   function automatic req_item_type address_event(input logic [DEV_ADDR_W-1:0] dev,
                                                  input logic rd);
      req_item_type ev;
      ev                   = '0;
      ev.address_stop_flag = 1'b1;
      ev.address_phase     = 1'b1;
      ev.direction_read    = rd;
      ev.data_flag         = 1'($urandom);
      ev.master_nack       = 1'($urandom);
      ev.rx_byte           = {dev, rd};
      return ev;
   endfunction

   function automatic req_item_type data_event(input logic rd, input logic nack,
                                               input logic [BYTE_W-1:0] value);
      req_item_type ev;
      ev                = '0;
      ev.data_flag      = 1'b1;
      ev.address_phase  = 1'($urandom);
      ev.direction_read = rd;
      ev.master_nack    = nack;
      ev.rx_byte        = value;
      return ev;
   endfunction

   function automatic req_item_type stop_event();
      req_item_type ev;
      ev                   = '0;
      ev.address_stop_flag = 1'b1;
      ev.data_flag         = 1'($urandom);
      ev.direction_read    = 1'($urandom);
      ev.master_nack       = 1'($urandom);
      ev.rx_byte           = 8'($urandom);
      return ev;
   endfunction

   function automatic req_item_type noise_event();
      logic [31:0] raw;
      raw = $urandom;
      return req_item_type'(raw[$bits(req_item_type)-1:0]);
   endfunction

   function automatic logic [DEV_ADDR_W-1:0] pick_device();
      case ($urandom_range(0, 7))
         0, 1, 2: return read_dev_addr;
         3, 4, 5: return write_dev_addr;
         6: return 7'($urandom);
         default: return ($urandom_range(0, 1) != 0) ? 7'h7F : 7'h00;
      endcase
   endfunction

   task automatic send_event(input req_item_type ev);
      req_bus.valid             <= 1'b1;
      req_bus.bus_error         <= ev.bus_error;
      req_bus.collision         <= ev.collision;
      req_bus.address_stop_flag <= ev.address_stop_flag;
      req_bus.address_phase     <= ev.address_phase;
      req_bus.data_flag         <= ev.data_flag;
      req_bus.direction_read    <= ev.direction_read;
      req_bus.master_nack       <= ev.master_nack;
      req_bus.rx_byte           <= ev.rx_byte;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      respond_to_event(ev);
      requests_accepted++;
      if (gaps_enabled && burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(0, 24);
      end else if (burst_left != 0) begin
         burst_left--;
      end
   endtask

   task automatic drain_replies();
      req_bus.valid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= idx;
      csr_bus.wr_data   <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
      if (idx == CSR_READ_DEV)
         read_dev_addr = value[DEV_ADDR_W-1:0];
      else
         write_dev_addr = value[DEV_ADDR_W-1:0];
   endtask

   task automatic write_transfer(input logic [DEV_ADDR_W-1:0] dev);
      int unsigned       count;
      logic [BYTE_W-1:0] first;
      count = $urandom_range(1, 6);
      first = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom);
      send_event(address_event(dev, 1'b0));
      send_event(data_event(1'b0, 1'($urandom), first));
      repeat (count) send_event(data_event(1'b0, 1'($urandom), 8'($urandom)));
      if ($urandom_range(0, 3) != 0)
         send_event(stop_event());
   endtask

   task automatic read_transfer(input logic [DEV_ADDR_W-1:0] dev, input bit set_pointer);
      if (set_pointer) begin
         send_event(address_event(dev, 1'b0));
         send_event(data_event(1'b0, 1'($urandom), 8'($urandom)));
      end
      send_event(address_event(dev, 1'b1));
      // A write-direction byte first takes the pointer-load path when the pointer is zero.
      if ($urandom_range(0, 2) == 0)
         send_event(data_event(1'b0, 1'b0, 8'($urandom)));
      repeat ($urandom_range(0, 5)) send_event(data_event(1'b1, 1'b0, 8'($urandom)));
      send_event(data_event(1'b1, 1'b1, 8'($urandom)));
      if ($urandom_range(0, 3) != 0)
         send_event(stop_event());
   endtask

   task automatic run_bus_traffic(input int unsigned items);
      int unsigned goal;
      goal = requests_accepted + items;
      while (requests_accepted < goal) begin
         case ($urandom_range(0, 9))
            0, 1, 2: write_transfer(pick_device());
            3, 4, 5: read_transfer(pick_device(), 1'b1);
            6, 7: read_transfer(pick_device(), 1'b0);
            8: send_event(noise_event());
            default: send_event(stop_event());
         endcase
      end
   endtask

   task automatic test_directed_transfers();
      req_item_type ev;
      // Fill two bytes of the store through the write device.
      send_event(address_event(WRITE_DEV_RESET, 1'b0));
      send_event(data_event(1'b0, 1'b0, 8'h10));
      send_event(data_event(1'b0, 1'b0, 8'hA5));
      send_event(data_event(1'b0, 1'b1, 8'h5A));
      send_event(stop_event());
      // The pointer wraps past the last byte; the byte after the wrap loads the pointer.
      send_event(address_event(WRITE_DEV_RESET, 1'b0));
      send_event(data_event(1'b0, 1'b0, 8'hFF));
      send_event(data_event(1'b0, 1'b0, 8'h00));
      send_event(data_event(1'b0, 1'b0, 8'h3C));
      // Set the pointer, then a repeated start reads from it.
      send_event(address_event(READ_DEV_RESET, 1'b0));
      send_event(data_event(1'b0, 1'b0, 8'h10));
      send_event(address_event(READ_DEV_RESET, 1'b1));
      send_event(data_event(1'b1, 1'b0, 8'h00));
      send_event(data_event(1'b1, 1'b0, 8'hFF));
      send_event(data_event(1'b1, 1'b1, 8'h00));
      // A master NACK with nothing sent yet still sends.
      send_event(address_event(READ_DEV_RESET, 1'b1));
      send_event(data_event(1'b1, 1'b1, 8'h00));
      // Read of an unknown device, pointer loaded from a write-direction byte.
      send_event(address_event(7'h7F, 1'b1));
      send_event(data_event(1'b0, 1'b0, 8'hFF));
      send_event(data_event(1'b0, 1'b0, 8'h00));
      send_event(address_event(READ_DEV_RESET, 1'b1));
      send_event(data_event(1'b0, 1'b1, 8'hFF));
      ev = '1;
      send_event(ev);
      ev.bus_error = 1'b0;
      send_event(ev);
      ev = '0;
      ev.rx_byte = 8'hFF;
      send_event(ev);
      send_event(address_event(7'h00, 1'b0));
      send_event(stop_event());
   endtask

   task automatic test_backpressure();
      drain_replies();
      gaps_enabled = 1'b0;
      holdoff_request = 300;
      run_bus_traffic(30);
      gaps_enabled = 1'b1;
      drain_replies();
      run_bus_traffic(10);
   endtask

   task automatic test_device_settings();
      logic [CSR_DATA_W-1:0] shared;
      drain_replies();
      write_csr(CSR_READ_DEV, 8'h00);
      write_csr(CSR_WRITE_DEV, 8'h00);
      run_bus_traffic(70);
      drain_replies();
      // Bit 7 of the write data lies above the seven-bit address.
      write_csr(CSR_READ_DEV, 8'hFF);
      write_csr(CSR_WRITE_DEV, 8'hFF);
      run_bus_traffic(70);
      drain_replies();
      write_csr(CSR_READ_DEV, 8'h7F);
      write_csr(CSR_WRITE_DEV, 8'h80);
      run_bus_traffic(70);
      drain_replies();
      shared = 8'($urandom);
      write_csr(CSR_WRITE_DEV, shared);
      write_csr(CSR_READ_DEV, shared);
      run_bus_traffic(60);
      drain_replies();
      write_csr(CSR_READ_DEV, 8'($urandom));
      write_csr(CSR_WRITE_DEV, 8'($urandom));
      run_bus_traffic(60);
   endtask

   // Receiver: a stall pattern, redrawn at random between all-ready and a random mask, plus requested hold-offs.
   initial begin
      int unsigned holdoff_left;
      int unsigned step;
      logic [15:0] pattern;
      holdoff_left = 0;
      step = 0;
      pattern = 16'hFFFF;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_request != 0) begin
            holdoff_left = holdoff_request;
            holdoff_request = 0;
         end
         if (holdoff_left != 0) begin
            holdoff_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (step % 64 == 0)
               pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
            rsp_bus.ready <= pattern[step % 16];
            step++;
         end
      end
   end

   always @(posedge clock) begin
      bus_reply_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_replies.size() == 0) begin
            report_mismatch($sformatf("unexpected result response=%0d tx_valid=%0b tx_byte=%02h",
                                      rsp_bus.response, rsp_bus.tx_valid, rsp_bus.tx_byte));
         end else begin
            want = expected_replies.pop_front();
            if (rsp_bus.response !== want.response)
               report_mismatch($sformatf("response %0d, expected %0d",
                                         rsp_bus.response, want.response));
            if (rsp_bus.tx_valid !== want.tx_valid)
               report_mismatch($sformatf("tx_valid %0b, expected %0b",
                                         rsp_bus.tx_valid, want.tx_valid));
            if (rsp_bus.tx_byte !== want.tx_byte)
               report_mismatch($sformatf("tx_byte %02h, expected %02h",
                                         rsp_bus.tx_byte, want.tx_byte));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      req_bus.valid             <= 1'b0;
      req_bus.bus_error         <= 1'b0;
      req_bus.collision         <= 1'b0;
      req_bus.address_stop_flag <= 1'b0;
      req_bus.address_phase     <= 1'b0;
      req_bus.data_flag         <= 1'b0;
      req_bus.direction_read    <= 1'b0;
      req_bus.master_nack       <= 1'b0;
      req_bus.rx_byte           <= '0;
      csr_bus.valid             <= 1'b0;
      csr_bus.reg_index         <= CSR_READ_DEV;
      csr_bus.wr_data           <= '0;
      read_dev_addr  = READ_DEV_RESET;
      write_dev_addr = WRITE_DEV_RESET;
      active_device  = '0;
      store_pointer  = '0;
      byte_sent      = 1'b0;
      reading        = 1'b0;
      foreach (stored_bytes[i]) stored_bytes[i] = ERASED_BYTE;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed_transfers();
      test_backpressure();
      test_device_settings();

      drain_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_replies.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_replies.size()));
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/i2cbs_pkg.sv
rtl/core/i2cbs_channels.sv
rtl/core/i2cbs_store.sv
rtl/core/i2c_slave_byte_store_responder_unit.sv
tb/i2c_slave_byte_store_responder_unit_test.sv
